>>> design/cholesky_solve_3x3_unit_assert.svh
// Assertion macros shared by the port checker.
`ifndef CHOLESKY_SOLVE_3X3_UNIT_ASSERT_SVH
`define CHOLESKY_SOLVE_3X3_UNIT_ASSERT_SVH

// same-cycle implication
`define CS3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cs3 port check failed");

// next-cycle implication
`define CS3_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cs3 port check failed");

`endif

>>> design/cs3_pkg.sv
// Package: types, constants and the solve microprogram for the 3x3 Cholesky solver.
`default_nettype none
package cs3_pkg;

  localparam int MATRIX_ORDER = 3;
  localparam int VAL_W        = 48;
  localparam int NUM_IN       = MATRIX_ORDER * MATRIX_ORDER + MATRIX_ORDER;
  localparam int IN_DATA_W    = NUM_IN * VAL_W;
  localparam int OUT_DATA_W   = MATRIX_ORDER * VAL_W;
  localparam int ACC_W        = 64;
  localparam int PROD_W       = 96;
  localparam int TOL_W        = 16;
  localparam int STAT_W       = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int RAM_DEPTH    = 12;
  localparam int RAM_AW       = $clog2(RAM_DEPTH);
  localparam int PC_W         = 6;
  localparam int CNT_W        = 6;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  // register index in the word address
  localparam logic REG_TOL = 1'b0;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_LOAD, OP_LDR, OP_MSUB, OP_SQRT, OP_DIV, OP_END
  } op_t;

  typedef enum logic [3:0] {
    F_M00, F_M10, F_M11, F_M20, F_M21, F_M22, F_P0, F_P1, F_P2
  } fsel_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_FETCH, BK_EXEC, BK_MUL, BK_MACC, BK_SQRT, BK_DIV, BK_DIVF, BK_DONE
  } bk_state_t;

  // scratch RAM map
  localparam logic [RAM_AW-1:0] R_L00 = 4'd0;
  localparam logic [RAM_AW-1:0] R_L10 = 4'd1;
  localparam logic [RAM_AW-1:0] R_L11 = 4'd2;
  localparam logic [RAM_AW-1:0] R_L20 = 4'd3;
  localparam logic [RAM_AW-1:0] R_L21 = 4'd4;
  localparam logic [RAM_AW-1:0] R_L22 = 4'd5;
  localparam logic [RAM_AW-1:0] R_Y0  = 4'd6;
  localparam logic [RAM_AW-1:0] R_Y1  = 4'd7;
  localparam logic [RAM_AW-1:0] R_Y2  = 4'd8;
  localparam logic [RAM_AW-1:0] R_X0  = 4'd9;
  localparam logic [RAM_AW-1:0] R_X1  = 4'd10;
  localparam logic [RAM_AW-1:0] R_X2  = 4'd11;

  typedef struct packed {
    op_t               op;
    fsel_t             fsel;
    logic [RAM_AW-1:0] ra;
    logic [RAM_AW-1:0] rb;
    logic [RAM_AW-1:0] rd;
  } uop_t;

  typedef struct packed {
    logic              asym;
    logic [VAL_W-1:0]  p2;
    logic [VAL_W-1:0]  p1;
    logic [VAL_W-1:0]  p0;
    logic [VAL_W-1:0]  m22;
    logic [VAL_W-1:0]  m21;
    logic [VAL_W-1:0]  m20;
    logic [VAL_W-1:0]  m11;
    logic [VAL_W-1:0]  m10;
    logic [VAL_W-1:0]  m00;
  } job_t;

  function automatic uop_t mk(op_t op, fsel_t fsel, logic [RAM_AW-1:0] ra,
                              logic [RAM_AW-1:0] rb, logic [RAM_AW-1:0] rd);
    uop_t u;
    u.op = op; u.fsel = fsel; u.ra = ra; u.rb = rb; u.rd = rd;
    return u;
  endfunction

  // factor, forward substitution, back substitution
  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_LOAD, F_M00, R_L00, R_L00, R_L00);
      6'd1:  u = mk(OP_SQRT, F_M00, R_L00, R_L00, R_L00);
      6'd2:  u = mk(OP_LOAD, F_M10, R_L00, R_L00, R_L00);
      6'd3:  u = mk(OP_DIV,  F_M00, R_L00, R_L00, R_L10);
      6'd4:  u = mk(OP_LOAD, F_M11, R_L00, R_L00, R_L00);
      6'd5:  u = mk(OP_MSUB, F_M00, R_L10, R_L10, R_L00);
      6'd6:  u = mk(OP_SQRT, F_M00, R_L00, R_L00, R_L11);
      6'd7:  u = mk(OP_LOAD, F_M20, R_L00, R_L00, R_L00);
      6'd8:  u = mk(OP_DIV,  F_M00, R_L00, R_L00, R_L20);
      6'd9:  u = mk(OP_LOAD, F_M21, R_L00, R_L00, R_L00);
      6'd10: u = mk(OP_MSUB, F_M00, R_L20, R_L10, R_L00);
      6'd11: u = mk(OP_DIV,  F_M00, R_L00, R_L11, R_L21);
      6'd12: u = mk(OP_LOAD, F_M22, R_L00, R_L00, R_L00);
      6'd13: u = mk(OP_MSUB, F_M00, R_L20, R_L20, R_L00);
      6'd14: u = mk(OP_MSUB, F_M00, R_L21, R_L21, R_L00);
      6'd15: u = mk(OP_SQRT, F_M00, R_L00, R_L00, R_L22);
      6'd16: u = mk(OP_LOAD, F_P0,  R_L00, R_L00, R_L00);
      6'd17: u = mk(OP_DIV,  F_M00, R_L00, R_L00, R_Y0);
      6'd18: u = mk(OP_LOAD, F_P1,  R_L00, R_L00, R_L00);
      6'd19: u = mk(OP_MSUB, F_M00, R_L10, R_Y0,  R_L00);
      6'd20: u = mk(OP_DIV,  F_M00, R_L00, R_L11, R_Y1);
      6'd21: u = mk(OP_LOAD, F_P2,  R_L00, R_L00, R_L00);
      6'd22: u = mk(OP_MSUB, F_M00, R_L20, R_Y0,  R_L00);
      6'd23: u = mk(OP_MSUB, F_M00, R_L21, R_Y1,  R_L00);
      6'd24: u = mk(OP_DIV,  F_M00, R_L00, R_L22, R_Y2);
      6'd25: u = mk(OP_LDR,  F_M00, R_Y2,  R_L00, R_L00);
      6'd26: u = mk(OP_DIV,  F_M00, R_L00, R_L22, R_X2);
      6'd27: u = mk(OP_LDR,  F_M00, R_Y1,  R_L00, R_L00);
      6'd28: u = mk(OP_MSUB, F_M00, R_L21, R_X2,  R_L00);
      6'd29: u = mk(OP_DIV,  F_M00, R_L00, R_L11, R_X1);
      6'd30: u = mk(OP_LDR,  F_M00, R_Y0,  R_L00, R_L00);
      6'd31: u = mk(OP_MSUB, F_M00, R_L10, R_X1,  R_L00);
      6'd32: u = mk(OP_MSUB, F_M00, R_L20, R_X2,  R_L00);
      6'd33: u = mk(OP_DIV,  F_M00, R_L00, R_L00, R_X0);
      default: u = mk(OP_END, F_M00, R_L00, R_L00, R_L00);
    endcase
    return u;
  endfunction

  function automatic logic [VAL_W-1:0] job_field(job_t j, fsel_t f);
    logic [VAL_W-1:0] v;
    unique case (f)
      F_M00:   v = j.m00;
      F_M10:   v = j.m10;
      F_M11:   v = j.m11;
      F_M20:   v = j.m20;
      F_M21:   v = j.m21;
      F_M22:   v = j.m22;
      F_P0:    v = j.p0;
      F_P1:    v = j.p1;
      F_P2:    v = j.p2;
      default: v = j.m00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> design/cs3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cs3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> design/cs3_front.sv
// Front end: takes requests, checks symmetry, builds the job for the queue.
`default_nettype none
module cs3_front (
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [cs3_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [cs3_pkg::TOL_W-1:0]      tol,
  input  wire logic                           q_full,
  output logic                                push,
  output cs3_pkg::job_t                       push_job
);
  import cs3_pkg::*;

  logic [VAL_W-1:0] fld [NUM_IN];

  function automatic logic pair_bad(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                    logic [TOL_W-1:0] t);
    logic signed [VAL_W:0] d;
    logic [VAL_W:0]        m;
    d = VAL_W'(signed'(a)) - VAL_W'(signed'(b));
    d = (VAL_W+1)'(signed'(a)) - (VAL_W+1)'(signed'(b));
    m = d[VAL_W] ? (VAL_W+1)'(-d) : (VAL_W+1)'(d);
    return m > (VAL_W+1)'(t);
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_IN; k++) begin
      fld[k] = in_tdata[k*VAL_W +: VAL_W];
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_job.m00  = fld[0];
    push_job.m10  = fld[3];
    push_job.m11  = fld[4];
    push_job.m20  = fld[6];
    push_job.m21  = fld[7];
    push_job.m22  = fld[8];
    push_job.p0   = fld[9];
    push_job.p1   = fld[10];
    push_job.p2   = fld[11];
    push_job.asym = pair_bad(fld[3], fld[1], tol) ||
                    pair_bad(fld[6], fld[2], tol) ||
                    pair_bad(fld[7], fld[5], tol);
  end
endmodule
`default_nettype wire

>>> design/cs3_queue.sv
// Job queue between front and back end.
`default_nettype none
module cs3_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  cs3_pkg::job_t push_job,
  input  wire logic  pop,
  output cs3_pkg::job_t head_job,
  output logic       full,
  output logic       empty
);
  import cs3_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t            ent_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end
endmodule
`default_nettype wire

>>> design/cs3_back.sv
// Back end: microcoded factor and solve with shared multiplier, divider and root unit.
`default_nettype none
module cs3_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  cs3_pkg::job_t                      job,
  input  wire logic                          q_empty,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [cs3_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [cs3_pkg::STAT_W-1:0]         out_tuser
);
  import cs3_pkg::*;

  bk_state_t               state_r, state_nxt;
  logic [PC_W-1:0]         pc_r, pc_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [VAL_W-1:0]        amag_r, amag_nxt, bmag_r, bmag_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [PROD_W-1:0]       rad_r, rad_nxt;
  logic [VAL_W+2:0]        rem_r, rem_nxt;
  logic [VAL_W-1:0]        root_r, root_nxt;
  logic [VAL_W:0]          dnum_r, dnum_nxt, dq_r, dq_nxt;
  logic [VAL_W-1:0]        drem_r, drem_nxt, den_r, den_nxt;
  logic                    dneg_r, dneg_nxt;
  logic [VAL_W-1:0]        x0_r, x0_nxt, x1_r, x1_nxt, x2_r, x2_nxt;
  status_t                 stat_r, stat_nxt;
  logic                    ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0]   od_r, od_nxt;
  logic [STAT_W-1:0]       os_r, os_nxt;

  uop_t                    uop;
  logic [VAL_W-1:0]        rd_a, rd_b;
  logic                    we;
  logic [VAL_W-1:0]        wdata;

  logic [23:0]             pa, pb;
  logic [2*24-1:0]         pp;
  logic [PROD_W-1:0]       pp_sh, t_rnd;
  logic signed [ACC_W-1:0] mv, sres;
  logic [ACC_W-1:0]        amag64;
  logic [VAL_W+2:0]        sq_r2, sq_trial;
  logic [VAL_W:0]          dv_r2, q_rnd;
  logic [VAL_W-1:0]        dv_res;

  assign uop = uop_rom(pc_r);

  cs3_ram #(.WIDTH(VAL_W), .DEPTH(RAM_DEPTH)) u_ram_a (
    .clk(clk), .we(we), .waddr(uop.rd), .wdata(wdata), .raddr(uop.ra), .rdata(rd_a)
  );
  cs3_ram #(.WIDTH(VAL_W), .DEPTH(RAM_DEPTH)) u_ram_b (
    .clk(clk), .we(we), .waddr(uop.rd), .wdata(wdata), .raddr(uop.rb), .rdata(rd_b)
  );

  // datapath helpers
  always_comb begin
    pa     = cnt_r[1] ? amag_r[47:24] : amag_r[23:0];
    pb     = cnt_r[0] ? bmag_r[47:24] : bmag_r[23:0];
    pp     = pa * pb;
    unique case (cnt_r[1:0])
      2'd0:    pp_sh = PROD_W'(pp);
      2'd3:    pp_sh = PROD_W'(pp) << 48;
      default: pp_sh = PROD_W'(pp) << 24;
    endcase
    t_rnd    = prod_r + PROD_W'(64'h8000_0000);
    mv       = signed'({2'b00, t_rnd[93:32]});
    sres     = neg_r ? acc_r + mv : acc_r - mv;
    amag64   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    sq_r2    = {rem_r[VAL_W:0], rad_r[PROD_W-1 -: 2]};
    sq_trial = {1'b0, root_r, 2'b01};
    dv_r2    = {drem_r, dnum_r[VAL_W]};
    q_rnd    = dq_r + 1'b1;
    dv_res   = dneg_r ? VAL_W'(-q_rnd[VAL_W:1]) : q_rnd[VAL_W:1];
  end

  always_comb begin
    state_nxt = state_r; pc_nxt = pc_r; acc_nxt = acc_r; prod_nxt = prod_r;
    amag_nxt = amag_r; bmag_nxt = bmag_r; neg_nxt = neg_r; cnt_nxt = cnt_r;
    rad_nxt = rad_r; rem_nxt = rem_r; root_nxt = root_r;
    dnum_nxt = dnum_r; dq_nxt = dq_r; drem_nxt = drem_r; den_nxt = den_r;
    dneg_nxt = dneg_r; x0_nxt = x0_r; x1_nxt = x1_r; x2_nxt = x2_r;
    stat_nxt = stat_r; od_nxt = od_r; os_nxt = os_r;
    ov_nxt = ov_r && !out_tready;
    we = 1'b0; wdata = root_r; pop = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pc_nxt = '0;
          if (job.asym) begin
            stat_nxt  = ST_FAIL;
            state_nxt = BK_DONE;
          end else begin
            state_nxt = BK_FETCH;
          end
        end
      end
      BK_FETCH: state_nxt = BK_EXEC;
      BK_EXEC: begin
        unique case (uop.op)
          OP_LOAD: begin
            acc_nxt   = ACC_W'(signed'(job_field(job, uop.fsel)));
            pc_nxt    = pc_r + 1'b1;
            state_nxt = BK_FETCH;
          end
          OP_LDR: begin
            acc_nxt   = ACC_W'(signed'(rd_a));
            pc_nxt    = pc_r + 1'b1;
            state_nxt = BK_FETCH;
          end
          OP_MSUB: begin
            amag_nxt  = rd_a[VAL_W-1] ? VAL_W'(-rd_a) : rd_a;
            bmag_nxt  = rd_b[VAL_W-1] ? VAL_W'(-rd_b) : rd_b;
            neg_nxt   = rd_a[VAL_W-1] ^ rd_b[VAL_W-1];
            prod_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = BK_MUL;
          end
          OP_SQRT: begin
            if (acc_r <= 64'sd0) begin
              stat_nxt  = ST_FAIL;
              state_nxt = BK_DONE;
            end else begin
              rad_nxt   = {acc_r, 32'b0};
              rem_nxt   = '0;
              root_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = BK_SQRT;
            end
          end
          OP_DIV: begin
            if (amag64[ACC_W-1:16] >= rd_b) begin
              stat_nxt  = ST_OVF;
              state_nxt = BK_DONE;
            end else begin
              den_nxt   = rd_b;
              drem_nxt  = amag64[ACC_W-1:16];
              dnum_nxt  = {amag64[15:0], 33'b0};
              dq_nxt    = '0;
              dneg_nxt  = acc_r[ACC_W-1];
              cnt_nxt   = '0;
              state_nxt = BK_DIV;
            end
          end
          OP_END: begin
            stat_nxt  = ST_OK;
            state_nxt = BK_DONE;
          end
          default: begin
            stat_nxt  = ST_FAIL;
            state_nxt = BK_DONE;
          end
        endcase
      end
      BK_MUL: begin
        prod_nxt = prod_r + pp_sh;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) begin
          state_nxt = BK_MACC;
        end
      end
      BK_MACC: begin
        if (t_rnd[PROD_W-1:94] != '0 || sres > ACC_LIM || sres < -ACC_LIM) begin
          stat_nxt  = ST_OVF;
          state_nxt = BK_DONE;
        end else begin
          acc_nxt   = sres;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = BK_FETCH;
        end
      end
      BK_SQRT: begin
        if (sq_r2 >= sq_trial) begin
          rem_nxt  = sq_r2 - sq_trial;
          root_nxt = {root_r[VAL_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_r2;
          root_nxt = {root_r[VAL_W-2:0], 1'b0};
        end
        rad_nxt = rad_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VAL_W - 1)) begin
          we        = 1'b1;
          wdata     = root_nxt;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = BK_FETCH;
        end
      end
      BK_DIV: begin
        if (dv_r2 >= {1'b0, den_r}) begin
          drem_nxt = VAL_W'(dv_r2 - {1'b0, den_r});
          dq_nxt   = {dq_r[VAL_W-1:0], 1'b1};
        end else begin
          drem_nxt = VAL_W'(dv_r2);
          dq_nxt   = {dq_r[VAL_W-1:0], 1'b0};
        end
        dnum_nxt = dnum_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VAL_W)) begin
          state_nxt = BK_DIVF;
        end
      end
      BK_DIVF: begin
        if (dq_r >= {1'b0, {VAL_W{1'b1}}}) begin
          stat_nxt  = ST_OVF;
          state_nxt = BK_DONE;
        end else begin
          we    = 1'b1;
          wdata = dv_res;
          if (uop.rd == R_X0) x0_nxt = dv_res;
          if (uop.rd == R_X1) x1_nxt = dv_res;
          if (uop.rd == R_X2) x2_nxt = dv_res;
          pc_nxt    = pc_r + 1'b1;
          state_nxt = BK_FETCH;
        end
      end
      BK_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = (stat_r == ST_OK) ? {x2_r, x1_r, x0_r} : '0;
          os_nxt    = stat_r;
          pop       = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      pc_r    <= '0;
      stat_r  <= ST_OK;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      stat_r  <= stat_nxt;
      ov_r    <= ov_nxt;
    end
    acc_r <= acc_nxt;   prod_r <= prod_nxt; amag_r <= amag_nxt; bmag_r <= bmag_nxt;
    neg_r <= neg_nxt;   cnt_r <= cnt_nxt;   rad_r <= rad_nxt;   rem_r <= rem_nxt;
    root_r <= root_nxt; dnum_r <= dnum_nxt; dq_r <= dq_nxt;     drem_r <= drem_nxt;
    den_r <= den_nxt;   dneg_r <= dneg_nxt; x0_r <= x0_nxt;     x1_r <= x1_nxt;
    x2_r <= x2_nxt;     od_r <= od_nxt;     os_r <= os_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = os_r;
endmodule
`default_nettype wire

>>> design/cholesky_solve_3x3_unit.sv
// Top level of the 3x3 Cholesky solver: APB register, front end, job queue, back end.
//
// Solves M*q = p for a symmetric positive definite 3x3 matrix in signed Q16.32.
// A request is checked for symmetry on entry and queued; the back end then runs
// a microprogram on one shared unit set: a 24x24 multiplier used four times per
// product, a bit-serial divider and a bit-serial root unit. In the back end a
// request that fails stops at the failing step, and an asymmetric one goes
// straight to the done state without running the microprogram. New requests
// are taken while the queue has room, and a finished result waits in the output
// register without stopping the next solve.
// Status on out_tuser: 0 solved, 1 asymmetric or not positive definite,
// 2 overflow; the solution reads zero unless the status is 0.
`default_nettype none
module cholesky_solve_3x3_unit #(
  parameter int QUEUE_DEPTH = cs3_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [cs3_pkg::APB_AW-1:0]    cfg_paddr,
  input  wire logic [cs3_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic      [cs3_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // m_row0_col0, m_row0_col1, m_row0_col2, m_row1_col0 .. m_row2_col2,
  // rhs_elem0, rhs_elem1, rhs_elem2 (48 bits each)
  input  wire logic [cs3_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // sol_elem0, sol_elem1, sol_elem2 (48 bits each)
  output logic [cs3_pkg::OUT_DATA_W-1:0]     out_tdata,
  // solve_status
  output logic [cs3_pkg::STAT_W-1:0]         out_tuser
);
  import cs3_pkg::*;

  logic [TOL_W-1:0] tol_r, tol_nxt;
  logic             wr_en;
  logic             push, pop, q_full, q_empty;
  job_t             push_job, head_job;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_TOL) && (cfg_paddr[1:0] == 2'b00);
  assign tol_nxt    = wr_en ? cfg_pwdata[TOL_W-1:0] : tol_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_TOL) ? APB_DW'(tol_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  cs3_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .tol(tol_r), .q_full(q_full), .push(push), .push_job(push_job)
  );

  cs3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_job(push_job), .pop(pop),
    .head_job(head_job), .full(q_full), .empty(q_empty)
  );

  cs3_back u_back (
    .clk(clk), .rst_n(rst_n), .job(head_job), .q_empty(q_empty), .pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );
endmodule
`default_nettype wire

>>> design/cs3_checker.sv
// Port-level checker for the Cholesky solver, bound to the top level.
`default_nettype none
`include "cholesky_solve_3x3_unit_assert.svh"
module cs3_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          cfg_psel,
  input wire logic                          cfg_penable,
  input wire logic                          cfg_pwrite,
  input wire logic [cs3_pkg::APB_AW-1:0]    cfg_paddr,
  input wire logic [cs3_pkg::APB_DW-1:0]    cfg_pwdata,
  input wire logic [cs3_pkg::APB_DW-1:0]    cfg_prdata,
  input wire logic                          cfg_pready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [cs3_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [cs3_pkg::STAT_W-1:0]    out_tuser
);
  import cs3_pkg::*;

  `CS3_ASSERT_IMP(a_stat_code, out_tvalid, out_tuser != 2'd3)
  `CS3_ASSERT_IMP(a_fail_zero, out_tvalid && (out_tuser != ST_OK), out_tdata == '0)
  `CS3_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `CS3_ASSERT_NXT(a_tol_rd, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0, cfg_paddr != 3'd0 || cfg_prdata == {16'b0, $past(cfg_pwdata[15:0])})
endmodule

bind cholesky_solve_3x3_unit cs3_checker u_cs3_checker (
  .clk(clk), .rst_n(rst_n), .cfg_psel(cfg_psel), .cfg_penable(cfg_penable),
  .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
  .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);
`default_nettype wire
